@@ hdl/tilt_complementary_filter_defines.svh @@
// assertion macros shared by the tilt filter modules
`ifndef TILT_COMPLEMENTARY_FILTER_DEFINES_SVH
`define TILT_COMPLEMENTARY_FILTER_DEFINES_SVH

// property must hold whenever reset is released
`define TCF_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// implication checked in the next cycle
`define TCF_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (prop)) \
        else $error(msg);

`endif

@@ hdl/tcf_pkg.sv @@
// shared types and constants for the tilt filter
package tcf_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int ANG_W = 21;
    localparam int RAW_W = 16;
    localparam int US_W = 20;
    localparam int BLEND_W = 17;
    localparam int IN_W = 5 * RAW_W + US_W;
    localparam int IN_BYTES_W = ((IN_W + 7) / 8) * 8;
    localparam int OUT_W = 2 * ANG_W;
    localparam int OUT_BYTES_W = ((OUT_W + 7) / 8) * 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 17;

    localparam logic [15:0] ATAN_B_Q16 = 16'd39074;
    localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
    localparam logic [24:0] GYRO_Q56 = 25'd19190098;
    localparam logic [16:0] BLEND_ONE = 17'd65536;
    localparam logic [16:0] BLEND_RST = 17'd62259;

    typedef enum logic [1:0] {
        REG_BIAS_X = 2'd0,
        REG_BIAS_Y = 2'd1,
        REG_BLEND = 2'd2
    } reg_idx_t;

    // one queued sample
    typedef struct packed {
        logic signed [RAW_W-1:0] acc_x;
        logic signed [RAW_W-1:0] acc_y;
        logic signed [RAW_W-1:0] acc_z;
        logic signed [RAW_W:0]   corr_x;  // rate minus bias
        logic signed [RAW_W:0]   corr_y;
        logic [US_W-1:0]         elapsed_us;
    } sample_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ,        // squares of the other axes
        ST_SQRT,      // bit-serial root
        ST_PROD,      // xq * yq
        ST_PB,        // p = round(b * xq*yq)
        ST_DIV,       // restoring divide
        ST_ANG,       // q * pi/2
        ST_GYRO1,     // r * us
        ST_GYRO2,     // * gyro factor
        ST_BLEND1,    // w * (tilt + delta)
        ST_BLEND2,    // (1-w) * acc, sum, round, saturate
        ST_OUT
    } back_state_t;

endpackage

@@ hdl/tcf_front.sv @@
// front part: accepts samples and config writes, applies bias, writes the queue
module tcf_front (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [tcf_pkg::IN_BYTES_W-1:0]  s_tdata,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [tcf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tcf_pkg::CFG_DATA_W-1:0]  cfg_data,
    output logic [tcf_pkg::BLEND_W-1:0]     blend_w,
    output logic                            q_valid,
    input  logic                            q_ready,
    output tcf_pkg::sample_t                q_data
);
    import tcf_pkg::*;

    logic signed [RAW_W-1:0] bias_x_reg, bias_x_next;
    logic signed [RAW_W-1:0] bias_y_reg, bias_y_next;
    logic [BLEND_W-1:0]      blend_reg, blend_next;
    sample_t                 slot_reg [2];
    logic [1:0]              cnt_reg, cnt_next;
    logic                    wr_ptr_reg, rd_ptr_reg;
    logic                    push, pop;
    sample_t                 incoming;

    assign cfg_ready = 1'b1;
    assign s_tready = (cnt_reg != 2'd2);
    assign push = s_tvalid && s_tready;
    assign pop = q_valid && q_ready;
    assign q_valid = (cnt_reg != 2'd0);
    assign q_data = slot_reg[rd_ptr_reg];
    // saturate blend to one
    assign blend_w = (blend_reg > BLEND_ONE) ? BLEND_ONE : blend_reg;

    always_comb begin
        incoming.acc_x = s_tdata[15:0];
        incoming.acc_y = s_tdata[31:16];
        incoming.acc_z = s_tdata[47:32];
        incoming.corr_x = {s_tdata[63], s_tdata[63:48]} - {bias_x_reg[15], bias_x_reg};
        incoming.corr_y = {s_tdata[79], s_tdata[79:64]} - {bias_y_reg[15], bias_y_reg};
        incoming.elapsed_us = s_tdata[99:80];
    end

    always_comb begin
        bias_x_next = bias_x_reg;
        bias_y_next = bias_y_reg;
        blend_next = blend_reg;
        if (cfg_valid) begin
            case (reg_idx_t'(cfg_index))
                REG_BIAS_X: bias_x_next = cfg_data[15:0];
                REG_BIAS_Y: bias_y_next = cfg_data[15:0];
                REG_BLEND:  blend_next = cfg_data;
                default:    ;
            endcase
        end
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bias_x_reg <= '0;
            bias_y_reg <= '0;
            blend_reg <= BLEND_RST;
            cnt_reg <= '0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end else begin
            bias_x_reg <= bias_x_next;
            bias_y_reg <= bias_y_next;
            blend_reg <= blend_next;
            cnt_reg <= cnt_next;
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop) rd_ptr_reg <= ~rd_ptr_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) slot_reg[wr_ptr_reg] <= incoming;
    end

`include "tilt_complementary_filter_defines.svh"
    `TCF_ASSERT(a_cnt_range, cnt_reg != 2'd3, "queue count out of range")
    `TCF_ASSERT_NEXT(a_full_stalls, cnt_reg == 2'd2 && !pop, !s_tready, "full queue must stall")
    `TCF_ASSERT_NEXT(a_push_only, push && !pop, cnt_reg == $past(cnt_reg) + 2'd1, "count slip")

endmodule

@@ hdl/tcf_back.sv @@
// back part: accelerometer tilt, gyro integration and blend per axis
module tcf_back #(
    parameter int FRAC_BITS = tcf_pkg::FRAC_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           q_valid,
    output logic                           q_ready,
    input  tcf_pkg::sample_t               q_data,
    input  logic [tcf_pkg::BLEND_W-1:0]    blend_w,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [tcf_pkg::OUT_BYTES_W-1:0] m_tdata
);
    import tcf_pkg::*;

    localparam int GSH = 56 - FRAC_BITS;
    localparam int DW = 48 + FRAC_BITS;  // dividend width
    localparam int DIV_CNT_W = $clog2(DW + 1);
    localparam int ACC_W = FRAC_BITS + 3;     // accelerometer angle
    localparam int DLT_W = FRAC_BITS + 8;     // gyro increment
    localparam int V_W = ANG_W + FRAC_BITS;   // blended angle before saturation

    back_state_t state_reg, state_next;
    sample_t     smp_reg;
    logic        axis_reg;  // 0 = x, 1 = y
    logic signed [ANG_W-1:0] tilt_reg [2];
    logic [OUT_BYTES_W-1:0]  out_reg;
    logic        out_valid_reg;

    logic [40:0] s_reg;      // (o1^2+o2^2)*256
    logic [31:0] a2_reg;     // squares sum before shift
    logic [41:0] rem_reg;    // root remainder
    logic [20:0] root_reg;
    logic [4:0]  cnt_reg;
    logic [DIV_CNT_W-1:0] dcnt_reg;
    logic [19:0] yq_reg;
    logic [40:0] xy_reg;
    logic [42:0] p_reg;
    logic [DW-1:0] num_reg;
    logic [43:0] den_reg;
    logic [44:0] drem_reg;
    logic [FRAC_BITS+1:0] q_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [37:0] ru_reg;
    logic signed [63:0] big_reg;
    logic signed [63:0] wsum_reg;
    logic neg_reg;

    logic signed [RAW_W-1:0] a_sel, o1_sel;
    logic [RAW_W-1:0] a_mag;
    logic signed [RAW_W:0] r_sel;
    logic [42:0] rtry;
    logic [44:0] dtry;
    logic [63:0] gmag;
    logic signed [DLT_W-1:0] delta_c;
    logic signed [63:0] blend_sum, vmag_s;
    logic [63:0] vmag;
    logic signed [V_W-1:0] vnew;
    logic signed [ANG_W-1:0] vsat;
    logic [FRAC_BITS+32:0] angp;

    assign a_sel = axis_reg ? smp_reg.acc_y : smp_reg.acc_x;
    assign o1_sel = axis_reg ? smp_reg.acc_x : smp_reg.acc_y;
    assign a_mag = a_sel[15] ? 16'(-a_sel) : a_sel;
    assign r_sel = axis_reg ? smp_reg.corr_y : smp_reg.corr_x;
    assign rtry = {rem_reg[39:0], s_reg[40:39]} - {root_reg, 2'b01};
    assign dtry = {drem_reg[43:0], num_reg[DW-1]} - {1'b0, den_reg};
    assign gmag = big_reg[63] ? 64'(-big_reg) : 64'(big_reg);
    assign delta_c = big_reg[63] ? -DLT_W'((gmag + (64'd1 << (GSH-1))) >> GSH) :
                     DLT_W'((gmag + (64'd1 << (GSH-1))) >> GSH);
    assign angp = q_reg * HALF_PI_Q30;
    assign blend_sum = wsum_reg + 64'(BLEND_ONE - blend_w) * 64'(acc_reg);
    assign vmag = blend_sum[63] ? 64'(-blend_sum) : 64'(blend_sum);
    assign vmag_s = 64'((vmag + 64'd32768) >> 16);
    assign vnew = blend_sum[63] ? V_W'(-vmag_s) : V_W'(vmag_s);
    assign vsat = (vnew > V_W'(1048575)) ? ANG_W'(1048575) :
                  (vnew < -V_W'(1048576)) ? ANG_W'(-1048576) : vnew[ANG_W-1:0];

    assign q_ready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata = out_reg;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (q_valid) state_next = ST_SQ;
            ST_SQ:     state_next = ST_SQRT;
            ST_SQRT:   if (cnt_reg == 5'd20) state_next = ST_PROD;
            ST_PROD:   state_next = ST_PB;
            ST_PB:     state_next = ST_DIV;
            ST_DIV:    if (dcnt_reg == DIV_CNT_W'(DW)) state_next = ST_ANG;
            ST_ANG:    state_next = ST_GYRO1;
            ST_GYRO1:  state_next = ST_GYRO2;
            ST_GYRO2:  state_next = ST_BLEND1;
            ST_BLEND1: state_next = ST_BLEND2;
            ST_BLEND2: state_next = axis_reg ? ST_OUT : ST_SQ;
            ST_OUT:    if (!out_valid_reg || m_tready) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            out_valid_reg <= 1'b0;
            axis_reg <= 1'b0;
            tilt_reg[0] <= '0;
            tilt_reg[1] <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_OUT && (!out_valid_reg || m_tready)) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: axis_reg <= 1'b0;
                ST_BLEND2: begin
                    tilt_reg[axis_reg] <= vsat;
                    axis_reg <= ~axis_reg;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: smp_reg <= q_data;
            ST_SQ: begin
                a2_reg <= 32'(o1_sel * o1_sel) + 32'(smp_reg.acc_z * smp_reg.acc_z);
                yq_reg <= {a_mag, 4'd0};
                neg_reg <= a_sel[15];
                cnt_reg <= '0;
                rem_reg <= '0;
                root_reg <= '0;
                s_reg <= '0;
            end
            ST_SQRT: begin
                // first cycle loads the radicand, then one root bit per cycle
                if (cnt_reg == 5'd0) begin
                    s_reg <= {a2_reg, 8'd0, 1'b0};
                    den_reg <= 44'({a2_reg, 8'd0});
                end else begin
                    s_reg <= {s_reg[38:0], 2'b00};
                    if (!rtry[42]) begin
                        rem_reg <= rtry[41:0];
                        root_reg <= {root_reg[19:0], 1'b1};
                    end else begin
                        rem_reg <= {rem_reg[39:0], s_reg[40:39]};
                        root_reg <= {root_reg[19:0], 1'b0};
                    end
                end
                cnt_reg <= cnt_reg + 5'd1;
            end
            ST_PROD: xy_reg <= 41'(root_reg * yq_reg);
            ST_PB: begin
                p_reg <= 43'((57'(xy_reg) * ATAN_B_Q16 + 57'd32768) >> 16);
                num_reg <= '0;
                drem_reg <= '0;
                dcnt_reg <= '0;
                q_reg <= '0;
            end
            ST_DIV: begin
                if (dcnt_reg == '0) begin
                    num_reg <= DW'({(44'(p_reg) + 44'(yq_reg * yq_reg)), FRAC_BITS'(0)});
                    den_reg <= den_reg + 44'({p_reg, 1'b0}) + 44'(yq_reg * yq_reg);
                    drem_reg <= '0;
                end else begin
                    num_reg <= {num_reg[DW-2:0], 1'b0};
                    if (den_reg != '0 && !dtry[44]) begin
                        drem_reg <= dtry;
                        q_reg <= {q_reg[FRAC_BITS:0], 1'b1};
                    end else begin
                        drem_reg <= {drem_reg[43:0], num_reg[DW-1]};
                        q_reg <= {q_reg[FRAC_BITS:0], 1'b0};
                    end
                end
                dcnt_reg <= dcnt_reg + DIV_CNT_W'(1);
            end
            ST_ANG: acc_reg <= neg_reg ?
                -ACC_W'((angp + (FRAC_BITS+33)'(1 << 29)) >> 30) :
                ACC_W'((angp + (FRAC_BITS+33)'(1 << 29)) >> 30);
            ST_GYRO1: ru_reg <= r_sel * $signed({1'b0, smp_reg.elapsed_us});
            ST_GYRO2: big_reg <= 64'(ru_reg) * $signed({1'b0, GYRO_Q56});
            ST_BLEND1: wsum_reg <= 64'($signed({1'b0, blend_w})) *
                (64'(tilt_reg[axis_reg]) + 64'(delta_c));
            ST_BLEND2: ;
            ST_OUT: if (!out_valid_reg || m_tready)
                out_reg <= OUT_BYTES_W'({tilt_reg[1], tilt_reg[0]});
            default: ;
        endcase
    end

`include "tilt_complementary_filter_defines.svh"
    `TCF_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "result dropped")
    `TCF_ASSERT(a_busy_noaccept, !(q_ready && state_reg != ST_IDLE), "accept while busy")
    `TCF_ASSERT_NEXT(a_out_after, state_reg == ST_OUT && state_next == ST_IDLE, m_tvalid,
        "result not raised")

endmodule

@@ hdl/tilt_complementary_filter.sv @@
// Two-axis tilt filter. One sample (accelerometer x/y/z, gyro x/y, elapsed
// microseconds) enters on s_ and gives one result beat on m_ with both angles in
// signed radians Q(FRAC_BITS). A two-entry queue buffers samples; the back end
// handles one sample at a time, running the bit-serial root and restoring divide
// per axis, and its result can wait on m_tready.
// Registers: 0 bias_x, 1 bias_y, 2 blend (Q16); write only while idle.
module tilt_complementary_filter #(
    parameter int FRAC_BITS = tcf_pkg::FRAC_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // acc_x, acc_y, acc_z, rate_x, rate_y, elapsed_us, zero pad
    input  logic [tcf_pkg::IN_BYTES_W-1:0]   s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // angle_x, angle_y, zero pad
    output logic [tcf_pkg::OUT_BYTES_W-1:0]  m_tdata,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [tcf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tcf_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import tcf_pkg::*;

    logic    q_valid, q_ready;
    sample_t q_data;
    logic [BLEND_W-1:0] blend_w;

    tcf_front u_front (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_tdata,
        .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
        .blend_w, .q_valid, .q_ready, .q_data
    );

    tcf_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .aclk, .aresetn, .q_valid, .q_ready, .q_data, .blend_w,
        .m_tvalid, .m_tready, .m_tdata
    );

endmodule
